// ----- sv/tpsg_pkg.sv -----
`timescale 1ns / 1ps

package tpsg_pkg;

    // Default resolution of the heading fed to the sine/cosine table.
    localparam int SINE_TABLE_BITS_DEF = 10;

    // Field and port widths.
    localparam int COORD_W = 16;
    localparam int ANGLE_W = 16;
    localparam int COUNT_W = 10;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int TRIG_W  = 16;
    localparam int PROD_W  = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X       = 3'd0,
        REG_START_Y       = 3'd1,
        REG_START_HEADING = 3'd2,
        REG_START_LENGTH  = 3'd3,
        REG_TURN_STEP     = 3'd4,
        REG_LENGTH_STEP   = 3'd5,
        REG_SEGMENT_COUNT = 3'd6
    } cfg_reg_t;

    // Register values after reset.
    localparam logic [CFG_W-1:0]   START_LENGTH_RST  = 16'd16;
    localparam logic [CFG_W-1:0]   LENGTH_STEP_RST   = 16'd16;
    localparam logic [COUNT_W-1:0] SEGMENT_COUNT_RST = 10'd1;

    // Rotation constants for the table build: 2^32 angle units per circle,
    // amplitude 2^30 equals 1.0.
    localparam int CORDIC_ITERS = 16;
    localparam longint CORDIC_GAIN = 64'sd652032874;
    localparam longint ATAN_TAB [CORDIC_ITERS] = '{
        64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
        64'sd42667331,  64'sd21354465,  64'sd10679838,  64'sd5340245,
        64'sd2670163,   64'sd1335087,   64'sd667544,    64'sd333772,
        64'sd166886,    64'sd83443,     64'sd41722,     64'sd20861
    };

    // Round a 2^30 amplitude to Q1.14 and clamp it to plus or minus one.
    function automatic logic [TRIG_W-1:0] to_q14(input longint v);
        longint r;
        r = (v + 64'sd32768) >>> 16;
        if (r > 64'sd16384) begin
            r = 64'sd16384;
        end
        if (r < -64'sd16384) begin
            r = -64'sd16384;
        end
        return r[TRIG_W-1:0];
    endfunction

    // One table entry: {cos, sin} in Q1.14 for step k of the first quadrant.
    // Evaluated only while the table is built at elaboration.
    function automatic logic [2*TRIG_W-1:0] cordic_entry(input int k, input int bits);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = CORDIC_GAIN;
        y = 64'sd0;
        z = longint'(k) <<< (32 - bits);
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TAB[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TAB[i];
            end
        end
        return {to_q14(x), to_q14(y)};
    endfunction

endpackage

// ----- sv/turtle_polyspiral_segment_generator_unit.sv -----
`timescale 1ns / 1ps

// A segment word is valid on m_axis once its step word has gone through the
// table-read, product and output registers (three register stages).
// Throughput: one step word per cycle unless the output stalls; heading, length
// and counter update at acceptance, position in the last stage, so words follow
// back to back. Reset (aresetn low, synchronous) empties the pipeline, clears
// the pose, length and counter, and loads the registers with documented defaults.
module turtle_polyspiral_segment_generator_unit #(
    parameter int SINE_TABLE_BITS = tpsg_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [tpsg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tpsg_pkg::CFG_W-1:0]       cfg_wdata,

    // Step requests.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // [0] restart, rest zero
    input  logic                             s_axis_tuser,   // [0] pen_down

    // Segments.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [63:0]                      m_axis_tdata,   // from_x, from_y, to_x, to_y
    output logic                             m_axis_tuser,   // [0] draw
    output logic                             m_axis_tlast    // last_segment
);

    localparam int ADDR_W    = SINE_TABLE_BITS - 2;
    localparam int ROM_DEPTH = 1 << ADDR_W;
    localparam int CW = tpsg_pkg::COORD_W;
    localparam int TW = tpsg_pkg::TRIG_W;
    localparam int PW = tpsg_pkg::PROD_W;
    localparam int NW = tpsg_pkg::COUNT_W;
    localparam int DW = PW - 14;   // width of a rounded step

    typedef logic [2*TW-1:0] rom_t [ROM_DEPTH];

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k < ROM_DEPTH; k++) begin
            r[k] = tpsg_pkg::cordic_entry(k, SINE_TABLE_BITS);
        end
        return r;
    endfunction

    // Quarter-wave table, {cos, sin} per entry.
    localparam rom_t SINE_ROM = build_rom();

    // Configuration registers.
    logic signed [CW-1:0]   start_x_reg, start_y_reg, start_length_reg;
    logic signed [CW-1:0]   turn_step_reg, length_step_reg;
    logic [CW-1:0]          start_heading_reg;
    logic [NW-1:0]          segment_count_reg;

    // Turtle state.
    logic [CW-1:0]          heading_reg, heading_next;
    logic signed [CW-1:0]   seg_length_reg, seg_length_next;
    logic [NW-1:0]          seg_done_reg, seg_done_next;
    logic signed [CW-1:0]   pos_x_reg, pos_y_reg;

    // Pipeline registers.
    logic                   s1_valid_reg, s2_valid_reg, m_valid_reg;
    logic [1:0]             s1_quad_reg;
    logic signed [CW-1:0]   s1_len_reg;
    logic                   s1_restart_reg, s1_pen_reg, s1_last_reg;
    logic [2*TW-1:0]        rom_q_reg;
    logic signed [PW-1:0]   s2_prod_x_reg, s2_prod_y_reg;
    logic                   s2_restart_reg, s2_pen_reg, s2_last_reg;
    logic signed [CW-1:0]   from_x_reg, from_y_reg, to_x_reg, to_y_reg;
    logic                   draw_reg, last_reg;

    // Handshake and stage advance.
    logic out_rdy, s2_rdy, s1_rdy, acc, adv2, adv3;

    assign out_rdy = !m_valid_reg || m_axis_tready;
    assign s2_rdy  = !s2_valid_reg || out_rdy;
    assign s1_rdy  = !s1_valid_reg || s2_rdy;
    assign acc     = s_axis_tvalid && s1_rdy;
    assign adv2    = s1_valid_reg && s2_rdy;
    assign adv3    = s2_valid_reg && out_rdy;

    assign s_axis_tready = s1_rdy;

    // Acceptance stage: restart reload, table address, state advance.
    logic                   restart_in;
    logic [CW-1:0]          heading_eff;
    logic signed [CW-1:0]   length_eff;
    logic [NW-1:0]          done_eff, done_inc;
    logic                   last_in;
    logic signed [CW:0]     length_sum;
    logic [ADDR_W-1:0]      rom_addr;

    always_comb begin
        restart_in  = s_axis_tdata[0];
        heading_eff = restart_in ? start_heading_reg : heading_reg;
        length_eff  = restart_in ? start_length_reg : seg_length_reg;
        done_eff    = restart_in ? '0 : seg_done_reg;
        done_inc    = done_eff + NW'(1);
        last_in     = (done_inc == segment_count_reg);
        rom_addr    = heading_eff[CW-3 -: ADDR_W];

        heading_next = heading_eff + $unsigned(turn_step_reg);
        length_sum   = {length_eff[CW-1], length_eff}
                     + {length_step_reg[CW-1], length_step_reg};
        if (length_sum[CW] != length_sum[CW-1]) begin
            seg_length_next = length_sum[CW] ? {1'b1, {(CW-1){1'b0}}}
                                             : {1'b0, {(CW-1){1'b1}}};
        end else begin
            seg_length_next = length_sum[CW-1:0];
        end
        seg_done_next = last_in ? '0 : done_inc;
    end

    // Stage one: map the quadrant and multiply by the length.
    logic signed [TW-1:0]   cq, sq, cos_v, sin_v;
    logic signed [PW-1:0]   prod_x, prod_y;

    always_comb begin
        cq = rom_q_reg[2*TW-1:TW];
        sq = rom_q_reg[TW-1:0];
        case (s1_quad_reg)
            2'd0: begin
                cos_v = cq;
                sin_v = sq;
            end
            2'd1: begin
                cos_v = -sq;
                sin_v = cq;
            end
            2'd2: begin
                cos_v = -cq;
                sin_v = -sq;
            end
            default: begin
                cos_v = sq;
                sin_v = -cq;
            end
        endcase
        prod_x = s1_len_reg * cos_v;
        prod_y = s1_len_reg * sin_v;
    end

    // Stage two: round the step, add it to the position and saturate.
    logic signed [PW-1:0]   rnd_x, rnd_y;
    logic signed [DW-1:0]   dx, dy;
    logic signed [CW-1:0]   base_x, base_y, sat_x, sat_y;
    logic signed [DW-1:0]   sum_x, sum_y;

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [DW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > DW'($signed({1'b0, {(CW-1){1'b1}}}))) begin
            r = {1'b0, {(CW-1){1'b1}}};
        end else if (v < -DW'($signed({1'b0, {(CW-1){1'b1}}})) - DW'(1)) begin
            r = {1'b1, {(CW-1){1'b0}}};
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    always_comb begin
        rnd_x  = s2_prod_x_reg + PW'(8192);
        rnd_y  = s2_prod_y_reg + PW'(8192);
        dx     = rnd_x[PW-1:14];
        dy     = rnd_y[PW-1:14];
        base_x = s2_restart_reg ? start_x_reg : pos_x_reg;
        base_y = s2_restart_reg ? start_y_reg : pos_y_reg;
        sum_x  = DW'(base_x) + dx;
        sum_y  = DW'(base_y) + dy;
        sat_x  = sat_coord(sum_x);
        sat_y  = sat_coord(sum_y);
    end

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            start_heading_reg <= '0;
            start_length_reg  <= tpsg_pkg::START_LENGTH_RST;
            turn_step_reg     <= '0;
            length_step_reg   <= tpsg_pkg::LENGTH_STEP_RST;
            segment_count_reg <= tpsg_pkg::SEGMENT_COUNT_RST;
        end else if (cfg_we) begin
            case (tpsg_pkg::cfg_reg_t'(cfg_index))
                tpsg_pkg::REG_START_X:       start_x_reg       <= cfg_wdata;
                tpsg_pkg::REG_START_Y:       start_y_reg       <= cfg_wdata;
                tpsg_pkg::REG_START_HEADING: start_heading_reg <= cfg_wdata;
                tpsg_pkg::REG_START_LENGTH:  start_length_reg  <= cfg_wdata;
                tpsg_pkg::REG_TURN_STEP:     turn_step_reg     <= cfg_wdata;
                tpsg_pkg::REG_LENGTH_STEP:   length_step_reg   <= cfg_wdata;
                tpsg_pkg::REG_SEGMENT_COUNT: segment_count_reg <= cfg_wdata[NW-1:0];
                default: ;
            endcase
        end
    end

    // Heading, length and counter move on as each word is accepted.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heading_reg    <= '0;
            seg_length_reg <= '0;
            seg_done_reg   <= '0;
        end else if (acc) begin
            heading_reg    <= heading_next;
            seg_length_reg <= seg_length_next;
            seg_done_reg   <= seg_done_next;
        end
    end

    // Position moves on as each segment enters the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end else if (adv3) begin
            pos_x_reg <= sat_x;
            pos_y_reg <= sat_y;
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_rdy) begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (s2_rdy) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_rdy) begin
                m_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload registers and the registered table read.
    always_ff @(posedge aclk) begin
        if (acc) begin
            rom_q_reg      <= SINE_ROM[rom_addr];
            s1_quad_reg    <= heading_eff[CW-1:CW-2];
            s1_len_reg     <= length_eff;
            s1_restart_reg <= restart_in;
            s1_pen_reg     <= s_axis_tuser;
            s1_last_reg    <= last_in;
        end
        if (adv2) begin
            s2_prod_x_reg  <= prod_x;
            s2_prod_y_reg  <= prod_y;
            s2_restart_reg <= s1_restart_reg;
            s2_pen_reg     <= s1_pen_reg;
            s2_last_reg    <= s1_last_reg;
        end
        if (adv3) begin
            from_x_reg <= base_x;
            from_y_reg <= base_y;
            to_x_reg   <= sat_x;
            to_y_reg   <= sat_y;
            draw_reg   <= s2_pen_reg;
            last_reg   <= s2_last_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {to_y_reg, to_x_reg, from_y_reg, from_x_reg};
    assign m_axis_tuser  = draw_reg;
    assign m_axis_tlast  = last_reg;

`ifndef SYNTHESIS
    // The counter starts over after the last segment of a spiral.
    a_count_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && last_in) |=> (seg_done_reg == '0))
        else $error("segment counter did not clear after the last segment");

    // The position kept is the end point just handed to the output.
    a_pos_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        adv3 |=> (pos_x_reg == to_x_reg && pos_y_reg == to_y_reg))
        else $error("position does not match the last end point");

    // A full, stalled pipeline takes no new word.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s2_valid_reg && m_valid_reg && !m_axis_tready)
        |-> !s_axis_tready)
        else $error("word accepted into a full pipeline");

    // A taken segment with nothing behind it is not shown again.
    a_no_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && !s2_valid_reg) |=> !m_axis_tvalid)
        else $error("segment word repeated");
`endif

endmodule
